>>> sv/csr_spmv_pkg.sv
// Shared types, request codes, field positions and saturation helper for the
// complex CSR sparse matrix-vector multiply block. No dependencies.
`default_nettype none

package csr_spmv_pkg;

    // Default parameter values for the top level.
    localparam int VEC_DEPTH_DEFAULT  = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Stream payload layout.
    localparam int COL_W       = 10;
    localparam int ELEM_W      = 32;
    localparam int IN_DATA_W   = 80;
    localparam int IN_COL_LSB  = 0;
    localparam int IN_RE_LSB   = 10;
    localparam int IN_IM_LSB   = 42;
    localparam int ROW_W       = 16;
    localparam int ACC_W       = 48;
    localparam int OUT_DATA_W  = 112;

    // Exact product combination width and the rounded partial width.
    localparam int DIFF_W      = 65;
    localparam int PART_W      = 50;
    localparam int FRAC_SHIFT  = 16;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2
    } req_type_t;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [ROW_W-1:0]         row_t;

    localparam acc_t  ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t  ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam part_t ACC_MAX_X = part_t'(ACC_MAX);
    localparam part_t ACC_MIN_X = part_t'(ACC_MIN);

    // Clamp a widened sum to the signed 48-bit accumulator range.
    function automatic acc_t sat_acc(input part_t x);
        acc_t r;
        if (x > ACC_MAX_X) begin
            r = ACC_MAX;
        end else if (x < ACC_MIN_X) begin
            r = ACC_MIN;
        end else begin
            r = acc_t'(x);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/csr_complex_spmv.sv
// Top level of the complex CSR sparse matrix-vector multiply block: vector
// store, complex multiply pipeline and row accumulator. Uses csr_spmv_pkg.
`default_nettype none

// Channel   Dir  Beat content (tdata from bit 0 up)                  Side bits
// s_*       in   column[9:0], elem_re[41:10], elem_im[73:42], pad      tuser = req_type,
//                                                                      tlast = row_end
// m_*       out  row_index[15:0], sum_re[63:16], sum_im[111:64]       none
//
// One input beat is taken per cycle while s_tready is high. A result
// passes four registers: the input/vector read register loaded at the
// edge that accepts the beat causing it, the product register, the
// rounded partial register, then the accumulator and output register. The
// rate is set by the 48-bit accumulate and saturate loop.
// Reset clears the stage valid bits, the accumulator and the row counter;
// the vector store is not cleared and must be loaded before it is read.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles are absorbed; while one result waits, input is still taken until
// all three stages hold a nonzero or empty-row beat, then s_tready falls.
module csr_complex_spmv #(
    parameter int VEC_DEPTH  = csr_spmv_pkg::VEC_DEPTH_DEFAULT,
    parameter int VALUE_BITS = csr_spmv_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // column[9:0], elem_re[41:10], elem_im[73:42], zero pad [79:74]
    input  wire logic [csr_spmv_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                           s_tuser,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // row_index[15:0], sum_re[63:16], sum_im[111:64]
    output logic [csr_spmv_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam int AW  = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int PW  = 2 * VALUE_BITS;
    localparam int CMP_W = 18;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                                  s_accept;
    logic [csr_spmv_pkg::COL_W-1:0]        in_col;
    logic signed [VALUE_BITS-1:0]          in_a;
    logic signed [VALUE_BITS-1:0]          in_b;
    logic [AW-1:0]                         in_addr;
    logic                                  in_range;
    logic                                  in_is_load;
    logic                                  in_is_nz;
    logic                                  in_is_empty;

    assign s_accept    = s_tvalid && s_tready;
    assign in_col      = s_tdata[csr_spmv_pkg::IN_COL_LSB +: csr_spmv_pkg::COL_W];
    assign in_a        = $signed(s_tdata[csr_spmv_pkg::IN_RE_LSB +: VALUE_BITS]);
    assign in_b        = $signed(s_tdata[csr_spmv_pkg::IN_IM_LSB +: VALUE_BITS]);
    assign in_addr     = AW'(in_col);
    assign in_range    = CMP_W'(in_col) < CMP_W'(VEC_DEPTH);
    assign in_is_load  = (s_tuser == csr_spmv_pkg::REQ_LOAD);
    assign in_is_nz    = (s_tuser == csr_spmv_pkg::REQ_NONZERO);
    assign in_is_empty = (s_tuser == csr_spmv_pkg::REQ_EMPTY);

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic out_valid_reg;
    logic take4, free3, free2, free1;
    logic out_load;

    logic nz1_reg, last1_reg, range1_reg;
    logic nz2_reg, last2_reg;
    logic nz3_reg, last3_reg;

    assign take4    = v3_reg && (!out_valid_reg || m_tready);
    assign free3    = !v3_reg || take4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign s_tready = free1;
    assign out_load = take4 && (!nz3_reg || last3_reg);

    // ------------------------------------------------------------------
    // Vector store: real part in the low half, imaginary in the high half.
    // A write and a read happen only at the edge that accepts their beat, so
    // a load is visible to every nonzero accepted after it.
    // ------------------------------------------------------------------
    logic [PW-1:0] vec_mem [VEC_DEPTH];
    logic [PW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept && in_is_load && in_range) begin
            vec_mem[in_addr] <= {in_b, in_a};
        end
        if (s_accept && in_is_nz) begin
            rd_reg <= vec_mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: operands and control of the accepted beat
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] a1_reg, b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else if (free1) begin
            v1_reg <= s_accept && (in_is_nz || in_is_empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1) begin
            a1_reg     <= in_a;
            b1_reg     <= in_b;
            nz1_reg    <= in_is_nz;
            last1_reg  <= s_tlast;
            range1_reg <= in_range;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: four exact partial products
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] c1, d1;
    logic signed [PW-1:0]         ac2_reg, bd2_reg, ad2_reg, bc2_reg;

    // A column past the store multiplies by zero.
    assign c1 = range1_reg ? $signed(rd_reg[VALUE_BITS-1:0]) : '0;
    assign d1 = range1_reg ? $signed(rd_reg[PW-1:VALUE_BITS]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end else if (free2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free2) begin
            ac2_reg   <= a1_reg * c1;
            bd2_reg   <= b1_reg * d1;
            ad2_reg   <= a1_reg * d1;
            bc2_reg   <= b1_reg * c1;
            nz2_reg   <= nz1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: combine exactly, then floor to Q32.16 by arithmetic shift
    // ------------------------------------------------------------------
    csr_spmv_pkg::diff_t re_full, im_full;
    csr_spmv_pkg::part_t re3_reg, im3_reg;

    assign re_full = csr_spmv_pkg::diff_t'(ac2_reg) - csr_spmv_pkg::diff_t'(bd2_reg);
    assign im_full = csr_spmv_pkg::diff_t'(ad2_reg) + csr_spmv_pkg::diff_t'(bc2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end else if (free3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3) begin
            re3_reg   <= csr_spmv_pkg::part_t'(re_full >>> csr_spmv_pkg::FRAC_SHIFT);
            im3_reg   <= csr_spmv_pkg::part_t'(im_full >>> csr_spmv_pkg::FRAC_SHIFT);
            nz3_reg   <= nz2_reg;
            last3_reg <= last2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: accumulate with saturation, emit rows
    // ------------------------------------------------------------------
    csr_spmv_pkg::acc_t acc_re_reg, acc_im_reg;
    csr_spmv_pkg::acc_t acc_re_next, acc_im_next;
    csr_spmv_pkg::row_t row_count_reg;
    csr_spmv_pkg::acc_t sum_re_reg, sum_im_reg;
    csr_spmv_pkg::row_t row_index_reg;

    assign acc_re_next = csr_spmv_pkg::sat_acc(csr_spmv_pkg::part_t'(acc_re_reg) + re3_reg);
    assign acc_im_next = csr_spmv_pkg::sat_acc(csr_spmv_pkg::part_t'(acc_im_reg) + im3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take4 && nz3_reg) begin
                // The last nonzero of a row restarts the accumulator.
                acc_re_reg <= last3_reg ? '0 : acc_re_next;
                acc_im_reg <= last3_reg ? '0 : acc_im_next;
            end
            if (out_load) begin
                row_count_reg <= row_count_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            row_index_reg <= row_count_reg;
            // An empty row reports zero and leaves any partial sum alone.
            sum_re_reg    <= nz3_reg ? acc_re_next : '0;
            sum_im_reg    <= nz3_reg ? acc_im_next : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sum_im_reg, sum_re_reg, row_index_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_empty_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take4 && !nz3_reg) |=> (m_tvalid && sum_re_reg == '0 && sum_im_reg == '0))
        else $error("empty row did not produce a zero result");

    a_row_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (row_count_reg == $past(row_count_reg) + 1'b1
                      && row_index_reg == $past(row_count_reg)))
        else $error("row counter and emitted row index disagree");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take4 && nz3_reg && last3_reg) |=> (acc_re_reg == '0 && acc_im_reg == '0))
        else $error("accumulator not cleared at row end");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the pipeline is full and stalled");

endmodule

`default_nettype wire
